FILE: hw/rtl/rrt_pkg.sv
package rrt_pkg;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_OVERLAP   = 3'd1,
        ST_FULL      = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_ZERO      = 3'd4
    } t_status;

    typedef enum logic {
        MODE_ACQUIRE = 1'b0,
        MODE_RELEASE = 1'b1
    } t_mode;

    localparam int POOL_W  = 3;
    localparam int OWNER_W = 8;
    localparam int RANGE_W = 64;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic clr;
        logic rd;
        logic wr;
        logic out_load;
    } t_dp_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic zero;
        logic clr_last;
        logic rd_last;
    } t_dp_sts;

    // final status of one request, zero count wins, then overlap, then full; a release with no match gives not found
    function automatic t_status status_calc(
        input logic zero,
        input t_mode mode,
        input logic ovl,
        input logic free_found,
        input logic hit
    );
        t_status s;
        s = ST_OK;
        if (zero) begin
            s = ST_ZERO;
        end else if (mode == MODE_ACQUIRE) begin
            if (ovl) begin
                s = ST_OVERLAP;
            end else if (!free_found) begin
                s = ST_FULL;
            end
        end else if (!hit) begin
            s = ST_NOT_FOUND;
        end
        return s;
    endfunction

endpackage

FILE: hw/rtl/rrt_datapath.sv
module rrt_datapath import rrt_pkg::*; #(
    parameter int SLOTS      = 32,
    parameter int OWNER_BITS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    output t_dp_sts            o_sts,
    input  logic               i_mode,
    input  logic [POOL_W-1:0]  i_pool,
    input  logic [OWNER_W-1:0] i_owner,
    input  logic [RANGE_W-1:0] i_range_base,
    input  logic [RANGE_W-1:0] i_range_count,
    output logic [2:0]         o_status
);

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    typedef struct packed {
        logic                  valid;
        logic [POOL_W-1:0]     pool;
        logic [OWNER_BITS-1:0] owner;
        logic [RANGE_W-1:0]    first;
        logic [RANGE_W-1:0]    span;
    } t_row;

    t_row mem [SLOTS];

    // request registers
    t_mode                 r_mode;
    logic [POOL_W-1:0]     r_pool;
    logic [OWNER_BITS-1:0] r_owner;
    logic [RANGE_W-1:0]    r_first;
    logic [RANGE_W-1:0]    r_span;
    logic [RANGE_W:0]      r_end;
    logic                  r_zero;

    // scan state
    logic [AW-1:0] r_addr;
    logic          r_chk;
    t_row          r_row;
    logic [AW-1:0] r_row_idx;
    logic          r_ovl;
    logic          r_free_found;
    logic [AW-1:0] r_free_idx;
    logic          r_hit;
    logic [AW-1:0] r_hit_idx;
    logic [2:0]    r_status;

    logic [RANGE_W:0] row_end;
    logic             row_same_pool;
    logic             row_ovl;
    logic             row_match;
    logic             wr_en;
    logic [AW-1:0]    wr_idx;
    t_row             wr_row;
    t_row             clr_row;

    always_comb begin
        row_end       = {1'b0, r_row.first} + {1'b0, r_row.span};
        row_same_pool = r_row.valid && (r_row.pool == r_pool);
        // ends taken exactly, one extra bit so nothing wraps
        row_ovl   = row_same_pool && ({1'b0, r_first} <= row_end)
                    && ({1'b0, r_row.first} <= r_end);
        row_match = row_same_pool && (r_row.owner == r_owner)
                    && (r_row.first == r_first) && (r_row.span == r_span);
    end

    always_comb begin
        wr_en = i_cmd.wr && !r_zero
                && (((r_mode == MODE_ACQUIRE) && !r_ovl && r_free_found)
                    || ((r_mode == MODE_RELEASE) && r_hit));
        wr_idx       = (r_mode == MODE_RELEASE) ? r_hit_idx : r_free_idx;
        wr_row.valid = (r_mode == MODE_ACQUIRE);
        wr_row.pool  = r_pool;
        wr_row.owner = r_owner;
        wr_row.first = r_first;
        wr_row.span  = r_span;
        clr_row      = '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) begin
            mem[r_addr] <= clr_row;
        end else if (wr_en) begin
            mem[wr_idx] <= wr_row;
        end
        if (i_cmd.rd) begin
            r_row     <= mem[r_addr];
            r_row_idx <= r_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode  <= t_mode'(i_mode);
            r_pool  <= i_pool;
            r_owner <= OWNER_BITS'(i_owner);
            r_first <= i_range_base;
            r_span  <= i_range_count - RANGE_W'(1);
            r_end   <= {1'b0, i_range_base} + {1'b0, i_range_count - RANGE_W'(1)};
            r_zero  <= (i_range_count == '0);
        end
        if (i_cmd.out_load) begin
            r_status <= status_calc(r_zero, r_mode, r_ovl, r_free_found, r_hit);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr       <= '0;
            r_chk        <= 1'b0;
            r_ovl        <= 1'b0;
            r_free_found <= 1'b0;
            r_free_idx   <= '0;
            r_hit        <= 1'b0;
            r_hit_idx    <= '0;
        end else begin
            r_chk <= i_cmd.rd;
            if (i_cmd.load) begin
                r_addr       <= '0;
                r_ovl        <= 1'b0;
                r_free_found <= 1'b0;
                r_hit        <= 1'b0;
            end else if (i_cmd.clr || i_cmd.rd) begin
                r_addr <= r_addr + AW'(1);
            end
            if (r_chk) begin
                if (!r_row.valid && !r_free_found) begin
                    r_free_found <= 1'b1;
                    r_free_idx   <= r_row_idx;
                end
                if (row_ovl) begin
                    r_ovl <= 1'b1;
                end
                if (row_match && !r_hit) begin
                    r_hit     <= 1'b1;
                    r_hit_idx <= r_row_idx;
                end
            end
        end
    end

    assign o_sts.zero     = r_zero;
    assign o_sts.clr_last = (r_addr == AW'(SLOTS - 1));
    assign o_sts.rd_last  = (r_addr == AW'(SLOTS - 1));
    assign o_status       = r_status;

endmodule

FILE: hw/rtl/rrt_ctrl.sv
module rrt_ctrl import rrt_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    output logic    o_valid,
    input  logic    i_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_SCAN  = 6'b000100,
        S_DRAIN = 6'b001000,
        S_WRITE = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   r_valid, n_valid;
    logic   out_free;

    assign out_free = !r_valid || i_ready;

    always_comb begin
        n_state = r_state;
        n_valid = r_valid && !i_ready;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.zero) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.rd = 1'b1;
                    if (i_sts.rd_last) begin
                        n_state = S_DRAIN;
                    end
                end
            end
            // last row read is checked here
            S_DRAIN: begin
                n_state = S_WRITE;
            end
            S_WRITE: begin
                o_cmd.wr = 1'b1;
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_valid        = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_valid;

endmodule

FILE: hw/rtl/range_reservation_table.sv
// Range reservation table: holds up to SLOTS reserved ranges, each tagged with a pool
// and an owner. An acquire word is checked against every valid entry of its pool and
// stored in the lowest free entry when nothing overlaps; a release word frees the
// entry with the same pool, owner, base and count. Each word gives one status word
// (0 ok, 1 overlap, 2 full, 3 not found, 4 zero count). The entries live in a
// single-port memory scanned one row per cycle; a zero count skips the scan. A new
// request is not taken until the status of the previous one has been loaded into
// the output register. After reset a clearing pass over all SLOTS entries runs
// before the first word is taken.
// A finished status sits in an output register, so the next word can be accepted
// while it waits.
module range_reservation_table import rrt_pkg::*; #(
    parameter int SLOTS      = 32,
    parameter int OWNER_BITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_mode,
    input  logic [2:0]  i_pool,
    input  logic [7:0]  i_owner,
    input  logic [63:0] i_range_base,
    input  logic [63:0] i_range_count,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_status
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    rrt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    rrt_datapath #(
        .SLOTS      (SLOTS),
        .OWNER_BITS (OWNER_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_mode        (i_mode),
        .i_pool        (i_pool),
        .i_owner       (i_owner),
        .i_range_base  (i_range_base),
        .i_range_count (i_range_count),
        .o_status      (o_status)
    );

endmodule

FILE: test/testbench.sv
module testbench;
    import rrt_pkg::*;

    localparam int SLOTS          = 32;
    localparam int CLK_HALF       = 2;
    localparam int RANDOM_WORDS   = 1450;
    localparam int IDLE_PCT       = 38;
    localparam int PHASE_WORDS    = 60;
    localparam int TIMEOUT_CYCLES = 400000;
    localparam int DRAIN_CYCLES   = 20000;

    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct {
        t_mode       mode;
        logic [2:0]  pool;
        logic [7:0]  owner;
        logic [63:0] base;
        logic [63:0] count;
        bit          fixed;
        t_status     status;
    } t_word;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_valid       = 1'b0;
    logic        i_mode        = 1'b0;
    logic [2:0]  i_pool        = '0;
    logic [7:0]  i_owner       = '0;
    logic [63:0] i_range_base  = '0;
    logic [63:0] i_range_count = '0;
    logic        i_ready       = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [2:0]  o_status;

    // shadow copy of the reservation table
    bit          held_valid[SLOTS];
    logic [2:0]  held_pool[SLOTS];
    logic [7:0]  held_owner[SLOTS];
    logic [63:0] held_first[SLOTS];
    logic [63:0] held_span[SLOTS];

    t_status pending_status[$];
    t_word   plan[$];
    t_status next_status;
    int      mismatches = 0;
    bit      steady     = 1'b0;

    always #CLK_HALF i_clk = ~i_clk;

    range_reservation_table #(
        .SLOTS      (SLOTS),
        .OWNER_BITS (8)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_mode        (i_mode),
        .i_pool        (i_pool),
        .i_owner       (i_owner),
        .i_range_base  (i_range_base),
        .i_range_count (i_range_count),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_status      (o_status)
    );

    // applies one request to the shadow table and returns its status
    function automatic t_status reserve_or_free(input t_mode m, input logic [2:0] p,
                                                input logic [7:0] o, input logic [63:0] b,
                                                input logic [63:0] c);
        logic [63:0] span;
        logic [64:0] req_last;
        logic [64:0] held_last;
        int          free_idx;
        int          i;
        if (c == '0) begin
            return ST_ZERO;
        end
        span     = c - 64'd1;
        free_idx = -1;
        if (m == MODE_ACQUIRE) begin
            // ends are taken one bit wider so a range past the top does not wrap
            req_last = {1'b0, b} + {1'b0, span};
            for (i = 0; i < SLOTS; i++) begin
                if (!held_valid[i]) begin
                    if (free_idx < 0) begin
                        free_idx = i;
                    end
                end else if (held_pool[i] == p) begin
                    held_last = {1'b0, held_first[i]} + {1'b0, held_span[i]};
                    if ({1'b0, b} <= held_last && {1'b0, held_first[i]} <= req_last) begin
                        return ST_OVERLAP;
                    end
                end
            end
            if (free_idx < 0) begin
                return ST_FULL;
            end
            held_valid[free_idx] = 1'b1;
            held_pool[free_idx]  = p;
            held_owner[free_idx] = o;
            held_first[free_idx] = b;
            held_span[free_idx]  = span;
            return ST_OK;
        end
        for (i = 0; i < SLOTS; i++) begin
            if (held_valid[i] && held_pool[i] == p && held_owner[i] == o &&
                held_first[i] == b && held_span[i] == span) begin
                held_valid[i] = 1'b0;
                return ST_OK;
            end
        end
        return ST_NOT_FOUND;
    endfunction

    function automatic int open_slots();
        int n;
        n = 0;
        foreach (held_valid[i]) begin
            if (!held_valid[i]) begin
                n++;
            end
        end
        return n;
    endfunction

    function automatic t_word word_of(input t_mode m, input logic [2:0] p,
                                      input logic [7:0] o, input logic [63:0] b,
                                      input logic [63:0] c, input bit fixed,
                                      input t_status st);
        t_word w;
        w.mode   = m;
        w.pool   = p;
        w.owner  = o;
        w.base   = b;
        w.count  = c;
        w.fixed  = fixed;
        w.status = st;
        return w;
    endfunction

    // releases of held entries (some with one bit flipped) or fresh random words, mostly acquires
    function automatic t_word random_word(input int acquire_pct);
        t_word w;
        int    held[$];
        int    i;
        int    r;
        w.fixed  = 1'b0;
        w.status = ST_OK;
        for (i = 0; i < SLOTS; i++) begin
            if (held_valid[i]) begin
                held.push_back(i);
            end
        end
        if (held.size() != 0 && $urandom_range(0, 99) >= acquire_pct) begin
            i       = held[$urandom_range(0, held.size() - 1)];
            w.mode  = MODE_RELEASE;
            w.pool  = held_pool[i];
            w.owner = held_owner[i];
            w.base  = held_first[i];
            w.count = held_span[i] + 64'd1;
            r = $urandom_range(0, 99);
            if (r < 5) begin
                w.pool ^= 3'(1 << $urandom_range(0, 2));
            end else if (r < 10) begin
                w.owner ^= 8'(1 << $urandom_range(0, 7));
            end else if (r < 15) begin
                w.base ^= 64'd1 << $urandom_range(0, 63);
            end else if (r < 20) begin
                w.count ^= 64'd1 << $urandom_range(0, 63);
            end
            return w;
        end
        w.mode  = ($urandom_range(0, 99) < 90) ? MODE_ACQUIRE : MODE_RELEASE;
        w.pool  = ($urandom_range(0, 99) < 60) ? 3'($urandom_range(0, 3))
                                               : 3'($urandom_range(0, 7));
        w.owner = 8'($urandom);
        r = $urandom_range(0, 99);
        if (r < 70) begin
            w.base = 64'($urandom_range(0, 511));
        end else if (r < 80) begin
            w.base = {$urandom, $urandom};
        end else if (r < 90) begin
            w.base = ALL_ONES - 64'($urandom_range(0, 300));
        end else begin
            w.base = 64'd1 << $urandom_range(0, 63);
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            w.count = '0;
        end else if (r < 75) begin
            w.count = 64'($urandom_range(1, 24));
        end else if (r < 85) begin
            w.count = {$urandom, $urandom};
        end else if (r < 95) begin
            w.count = 64'($urandom_range(1, 600));
        end else begin
            w.count = ALL_ONES - 64'($urandom_range(0, 3));
        end
        return w;
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_word(input t_word w);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_mode        <= w.mode;
        i_pool        <= w.pool;
        i_owner       <= w.owner;
        i_range_base  <= w.base;
        i_range_count <= w.count;
        do @(posedge i_clk); while (!o_ready);
        if (w.fixed) begin
            void'(reserve_or_free(w.mode, w.pool, w.owner, w.base, w.count));
            pending_status.push_back(w.status);
        end else begin
            pending_status.push_back(reserve_or_free(w.mode, w.pool, w.owner, w.base,
                                                     w.count));
        end
        @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        i_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_status.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("status word %0d with nothing outstanding", o_status);
                end
            end else begin
                next_status = pending_status.pop_front();
                if (o_status !== next_status) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("status mismatch: expected %0d, got %0d",
                                 next_status, o_status);
                    end
                end
            end
        end
    end

    initial begin
        int sent;
        int phase;
        int n;
        int waited;
        int acquire_pct;
        sent  = 0;
        phase = 0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        plan.push_back(word_of(MODE_ACQUIRE, 3'd0, 8'h00, 64'd0, 64'd0, 1'b1, ST_ZERO));
        plan.push_back(word_of(MODE_RELEASE, 3'd7, 8'hFF, ALL_ONES, 64'd0, 1'b1, ST_ZERO));
        plan.push_back(word_of(MODE_RELEASE, 3'd7, 8'hFF, 64'd0, 64'd1, 1'b1,
                               ST_NOT_FOUND));
        plan.push_back(word_of(MODE_ACQUIRE, 3'd0, 8'h01, 64'd0, 64'd1, 1'b1, ST_OK));
        plan.push_back(word_of(MODE_ACQUIRE, 3'd0, 8'h02, 64'd0, 64'd1, 1'b1, ST_OVERLAP));
        plan.push_back(word_of(MODE_ACQUIRE, 3'd1, 8'h02, 64'd0, 64'd1, 1'b1, ST_OK));
        plan.push_back(word_of(MODE_ACQUIRE, 3'd0, 8'h03, ALL_ONES, 64'd1, 1'b1, ST_OK));
        // runs far past the top without wrapping, still hits the top unit
        plan.push_back(word_of(MODE_ACQUIRE, 3'd0, 8'h04, ALL_ONES - 64'd1, ALL_ONES, 1'b1,
                               ST_OVERLAP));
        plan.push_back(word_of(MODE_ACQUIRE, 3'd2, 8'h80, 64'hFFFF_FFFF_FFFF_FFF0,
                               ALL_ONES, 1'b1, ST_OK));
        plan.push_back(word_of(MODE_ACQUIRE, 3'd2, 8'h7F, 64'd5, 64'd10, 1'b0, ST_OK));
        plan.push_back(word_of(MODE_ACQUIRE, 3'd2, 8'h00, 64'h8000_0000_0000_0000,
                               64'h8000_0000_0000_0000, 1'b0, ST_OK));
        plan.push_back(word_of(MODE_RELEASE, 3'd0, 8'h01, 64'd0, 64'd2, 1'b0, ST_OK));
        plan.push_back(word_of(MODE_RELEASE, 3'd1, 8'h01, 64'd0, 64'd1, 1'b0, ST_OK));
        plan.push_back(word_of(MODE_RELEASE, 3'd0, 8'h01, 64'd0, 64'd1, 1'b0, ST_OK));
        plan.push_back(word_of(MODE_ACQUIRE, 3'd3, 8'hAA, 64'd0, ALL_ONES, 1'b0, ST_OK));
        plan.push_back(word_of(MODE_ACQUIRE, 3'd3, 8'h55, ALL_ONES - 64'd1, 64'd1, 1'b0,
                               ST_OK));
        plan.push_back(word_of(MODE_RELEASE, 3'd3, 8'hAA, 64'd0, ALL_ONES, 1'b0, ST_OK));
        plan.push_back(word_of(MODE_RELEASE, 3'd3, 8'hAA, 64'd0, ALL_ONES, 1'b0, ST_OK));
        plan.push_back(word_of(MODE_ACQUIRE, 3'd7, 8'hFF, 64'h5555_5555_5555_5555,
                               64'hAAAA_AAAA_AAAA_AAAA, 1'b0, ST_OK));
        plan.push_back(word_of(MODE_ACQUIRE, 3'd4, 8'h01, 64'd100, 64'd50, 1'b0, ST_OK));
        plan.push_back(word_of(MODE_ACQUIRE, 3'd4, 8'h02, 64'd149, 64'd1, 1'b0, ST_OK));
        plan.push_back(word_of(MODE_ACQUIRE, 3'd4, 8'h03, 64'd150, 64'd10, 1'b0, ST_OK));
        plan.push_back(word_of(MODE_ACQUIRE, 3'd4, 8'h04, 64'd90, 64'd10, 1'b0, ST_OK));
        plan.push_back(word_of(MODE_ACQUIRE, 3'd4, 8'h05, 64'd90, 64'd11, 1'b0, ST_OK));
        foreach (plan[k]) begin
            send_word(plan[k]);
        end

        // fill the table in a pool nobody else uses, then hit it while full
        n = 0;
        while (open_slots() > 0) begin
            send_word(word_of(MODE_ACQUIRE, 3'd5, 8'($urandom), 64'(n * 100), 64'd10,
                              1'b0, ST_OK));
            n++;
            sent++;
        end
        send_word(word_of(MODE_ACQUIRE, 3'd5, 8'h11, 64'd105, 64'd3, 1'b0, ST_OK));
        send_word(word_of(MODE_ACQUIRE, 3'd6, 8'h22, 64'd0, 64'd1, 1'b0, ST_OK));
        sent += 2;

        while (sent < RANDOM_WORDS) begin
            steady = (phase == 3 || phase == 4);
            acquire_pct = (phase % 3 == 0) ? 80 : (phase % 3 == 1) ? 30 : 55;
            for (n = 0; n < PHASE_WORDS && sent < RANDOM_WORDS; n++) begin
                send_word(random_word(acquire_pct));
                sent++;
            end
            // let the block run dry before the next burst
            if (phase % 5 == 1) begin
                i_valid <= 1'b0;
                @(negedge i_clk);
                while (pending_status.size() != 0) begin
                    @(negedge i_clk);
                end
            end
            phase++;
        end
        steady = 1'b0;

        i_valid <= 1'b0;
        waited = 0;
        while (pending_status.size() != 0 && waited < DRAIN_CYCLES) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (3 * (SLOTS + 4)) @(negedge i_clk);
        if (pending_status.size() != 0) begin
            $display("%0d status words never arrived", pending_status.size());
        end
        if (mismatches == 0 && pending_status.size() == 0) begin
            $display("** range_reservation_table: PASSED **");
        end else begin
            $display("** range_reservation_table: FAILED **");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_CYCLES * 2 * CLK_HALF);
        $display("** range_reservation_table: FAILED **");
        $finish;
    end

endmodule
